// ===== sv/datamatrix_module_placement_unit_defines.svh =====
// Assertion macros used by the checker file of the placement unit.
`ifndef DATAMATRIX_MODULE_PLACEMENT_UNIT_DEFINES_SVH
`define DATAMATRIX_MODULE_PLACEMENT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DMP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("placement unit: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DMP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("placement unit: next-cycle check failed");

`endif

// ===== sv/dmp_pkg.sv =====
// Types, constants and coordinate functions of the Data Matrix placement unit.
package dmp_pkg;

	localparam int MAX_DIM       = 132;
	localparam int MIN_DIM       = 6;
	localparam int MAX_CODEWORDS = 2178;
	localparam int CW_AW         = 12;
	localparam int WORDS_PER_ROW = 5;
	localparam int MTX_DEPTH     = MAX_DIM * WORDS_PER_ROW;
	localparam int MTX_AW        = 10;
	localparam int MTX_DW        = 64;
	localparam logic [MTX_AW-1:0] MTX_LAST = MTX_AW'(MTX_DEPTH - 1);
	localparam logic [CW_AW-1:0]  CW_FULL  = CW_AW'(MAX_CODEWORDS);
	localparam logic [7:0]        FIX_BYTE = 8'hC0;

	typedef logic signed [9:0] coord_t;

	typedef enum logic [2:0] {
		SH_UTAH = 3'd0,
		SH_A    = 3'd1,
		SH_B    = 3'd2,
		SH_C    = 3'd3,
		SH_D    = 3'd4,
		SH_FIX  = 3'd5
	} shape_t;

	typedef struct packed {
		coord_t row;
		coord_t col;
	} pos_t;

	// Placement request from the host side to the walker.
	typedef struct packed {
		logic             start;
		logic [7:0]       nr;
		logic [7:0]       nc;
		logic [CW_AW-1:0] count;
	} walk_req_t;

	function automatic logic [7:0] clamp_dim(logic [7:0] v);
		logic [7:0] d;
		d = v;
		if (v < 8'(MIN_DIM)) d = 8'(MIN_DIM);
		if (v > 8'(MAX_DIM)) d = 8'(MAX_DIM);
		return d;
	endfunction

	// Entry of the row-word memory that holds a module: row * 5 + col / 32.
	function automatic logic [MTX_AW-1:0] mtx_addr(logic [7:0] row, logic [7:0] col);
		logic [MTX_AW:0] a;
		a = {1'b0, row, 2'b00} + {3'b000, row} + {8'b0, col[7:5]};
		return a[MTX_AW-1:0];
	endfunction

	// Unwrapped position of bit k (0 is the MSB) of a shape.
	function automatic pos_t shape_pos(shape_t kind, logic [2:0] k, coord_t r, coord_t c,
			coord_t nr, coord_t nc);
		pos_t p;
		p.row = '0;
		p.col = '0;
		unique case (kind)
			SH_UTAH: begin
				unique case (k)
					3'd0: begin p.row = r - 10'sd2; p.col = c - 10'sd2; end
					3'd1: begin p.row = r - 10'sd2; p.col = c - 10'sd1; end
					3'd2: begin p.row = r - 10'sd1; p.col = c - 10'sd2; end
					3'd3: begin p.row = r - 10'sd1; p.col = c - 10'sd1; end
					3'd4: begin p.row = r - 10'sd1; p.col = c;          end
					3'd5: begin p.row = r;          p.col = c - 10'sd2; end
					3'd6: begin p.row = r;          p.col = c - 10'sd1; end
					default: begin p.row = r;       p.col = c;          end
				endcase
			end
			SH_A: begin
				unique case (k)
					3'd0: begin p.row = nr - 10'sd1; p.col = 10'sd0;      end
					3'd1: begin p.row = nr - 10'sd1; p.col = 10'sd1;      end
					3'd2: begin p.row = nr - 10'sd1; p.col = 10'sd2;      end
					3'd3: begin p.row = 10'sd0;      p.col = nc - 10'sd2; end
					3'd4: begin p.row = 10'sd0;      p.col = nc - 10'sd1; end
					3'd5: begin p.row = 10'sd1;      p.col = nc - 10'sd1; end
					3'd6: begin p.row = 10'sd2;      p.col = nc - 10'sd1; end
					default: begin p.row = 10'sd3;   p.col = nc - 10'sd1; end
				endcase
			end
			SH_B: begin
				unique case (k)
					3'd0: begin p.row = nr - 10'sd3; p.col = 10'sd0;      end
					3'd1: begin p.row = nr - 10'sd2; p.col = 10'sd0;      end
					3'd2: begin p.row = nr - 10'sd1; p.col = 10'sd0;      end
					3'd3: begin p.row = 10'sd0;      p.col = nc - 10'sd4; end
					3'd4: begin p.row = 10'sd0;      p.col = nc - 10'sd3; end
					3'd5: begin p.row = 10'sd0;      p.col = nc - 10'sd2; end
					3'd6: begin p.row = 10'sd0;      p.col = nc - 10'sd1; end
					default: begin p.row = 10'sd1;   p.col = nc - 10'sd1; end
				endcase
			end
			SH_C: begin
				unique case (k)
					3'd0: begin p.row = nr - 10'sd3; p.col = 10'sd0;      end
					3'd1: begin p.row = nr - 10'sd2; p.col = 10'sd0;      end
					3'd2: begin p.row = nr - 10'sd1; p.col = 10'sd0;      end
					3'd3: begin p.row = 10'sd0;      p.col = nc - 10'sd2; end
					3'd4: begin p.row = 10'sd0;      p.col = nc - 10'sd1; end
					3'd5: begin p.row = 10'sd1;      p.col = nc - 10'sd1; end
					3'd6: begin p.row = 10'sd2;      p.col = nc - 10'sd1; end
					default: begin p.row = 10'sd3;   p.col = nc - 10'sd1; end
				endcase
			end
			SH_D: begin
				unique case (k)
					3'd0: begin p.row = nr - 10'sd1; p.col = 10'sd0;      end
					3'd1: begin p.row = nr - 10'sd1; p.col = nc - 10'sd1; end
					3'd2: begin p.row = 10'sd0;      p.col = nc - 10'sd3; end
					3'd3: begin p.row = 10'sd0;      p.col = nc - 10'sd2; end
					3'd4: begin p.row = 10'sd0;      p.col = nc - 10'sd1; end
					3'd5: begin p.row = 10'sd1;      p.col = nc - 10'sd3; end
					3'd6: begin p.row = 10'sd1;      p.col = nc - 10'sd2; end
					default: begin p.row = 10'sd1;   p.col = nc - 10'sd1; end
				endcase
			end
			default: begin
				// fixed bottom-right pattern: four modules only
				unique case (k)
					3'd0: begin p.row = nr - 10'sd1; p.col = nc - 10'sd1; end
					3'd1: begin p.row = nr - 10'sd2; p.col = nc - 10'sd2; end
					3'd2: begin p.row = nr - 10'sd1; p.col = nc - 10'sd2; end
					default: begin p.row = nr - 10'sd2; p.col = nc - 10'sd1; end
				endcase
			end
		endcase
		return p;
	endfunction

	// Fold negative rows and columns back onto the matrix.
	function automatic pos_t wrap_pos(pos_t p, coord_t nr, coord_t nc);
		pos_t q;
		q = p;
		if (q.row < 10'sd0) begin
			q.row = q.row + nr;
			q.col = q.col + 10'sd4 - ((nr + 10'sd4) & 10'sd7);
		end
		if (q.col < 10'sd0) begin
			q.col = q.col + nc;
			q.row = q.row + 10'sd4 - ((nc + 10'sd4) & 10'sd7);
		end
		return q;
	endfunction

	function automatic logic on_matrix(coord_t r, coord_t c, coord_t nr, coord_t nc);
		return (r >= 10'sd0) && (r < nr) && (c >= 10'sd0) && (c < nc);
	endfunction

endpackage

// ===== sv/datamatrix_module_placement_unit.sv =====
// Data Matrix ECC200 placement unit: host stream side, codeword store and matrix.
//
// A load request's result is registered and ready the cycle after it is taken. A read
// request's result passes through the registered read of the row-word memory and then
// the output register; no new request is taken in between. A load marked last starts
// placement; its result goes out at once, and no request is taken until placement
// ends. Placement first clears the 660-entry matrix memory, one entry a cycle, then
// walks the zig-zag. A codeword placed as a utah shape goes through the filled-mark
// check, the store read, then for each of the 8 modules a position step, a read and a
// write-back of the matrix word over its single write port, and a step on. A visited
// position that is already filled, or off the matrix, is only checked and stepped
// past. The same clearing pass runs after reset, before the first request is taken.
module datamatrix_module_placement_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // codeword[7:0], read_row[15:8], read_word[18:16]
	input  logic        s_axis_tlast,  // last_codeword
	input  logic        s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // matrix_bits[31:0]
	output logic [1:0]  m_axis_tuser   // placed[0], overflow[1]
);

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;
	localparam logic OP_LOAD  = 1'b0;

	logic [7:0]                 num_rows_q, num_cols_q;
	logic [dmp_pkg::CW_AW-1:0]  count_q, eff_count, count_new;
	logic                       done_q, ovf_q, full;
	logic                       out_valid_q;
	logic [31:0]                out_bits_q;
	logic                       rd_s1;
	logic [31:0]                mask_s1, mask;
	logic                       in_acc, load_acc, read_acc;
	logic [7:0]                 rows, cols, read_row;
	logic [2:0]                 read_word;
	logic [8:0]                 col9;

	dmp_pkg::walk_req_t         req;
	logic                       busy;
	logic [dmp_pkg::CW_AW-1:0]  cw_raddr;
	logic [7:0]                 cw_rdata;
	logic                       mtx_we;
	logic [dmp_pkg::MTX_AW-1:0] mtx_waddr, walk_raddr, mtx_raddr;
	logic [dmp_pkg::MTX_DW-1:0] mtx_wdata, mtx_rdata;

	assign s_axis_tready = !busy && !rd_s1 && (!out_valid_q || m_axis_tready);
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign load_acc  = in_acc && (s_axis_tuser == OP_LOAD);
	assign read_acc  = in_acc && (s_axis_tuser != OP_LOAD);
	assign read_row  = s_axis_tdata[15:8];
	assign read_word = s_axis_tdata[18:16];

	assign rows      = dmp_pkg::clamp_dim(num_rows_q);
	assign cols      = dmp_pkg::clamp_dim(num_cols_q);
	assign eff_count = done_q ? '0 : count_q;
	assign full      = (eff_count >= dmp_pkg::CW_FULL);
	assign count_new = full ? eff_count : eff_count + 1'b1;

	always_comb begin
		mask = '0;
		col9 = '0;
		for (int i = 0; i < 32; i++) begin
			col9    = {1'b0, read_word, 5'b00000} + 9'(i);
			mask[i] = (read_row < rows) && (col9 < {1'b0, cols});
		end
	end

	assign req.start = load_acc && s_axis_tlast;
	assign req.nr    = rows;
	assign req.nc    = cols;
	assign req.count = count_new;

	assign mtx_raddr = busy ? walk_raddr : dmp_pkg::mtx_addr(read_row, {read_word, 5'b00000});

	dmp_cw_mem u_cw_mem (
		.clk   (clk),
		.we    (load_acc && !full),
		.waddr (eff_count),
		.wdata (s_axis_tdata[7:0]),
		.raddr (cw_raddr),
		.rdata (cw_rdata)
	);

	dmp_mtx_mem u_mtx_mem (
		.clk   (clk),
		.we    (mtx_we),
		.waddr (mtx_waddr),
		.wdata (mtx_wdata),
		.raddr (mtx_raddr),
		.rdata (mtx_rdata)
	);

	dmp_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.busy      (busy),
		.cw_raddr  (cw_raddr),
		.cw_rdata  (cw_rdata),
		.mtx_we    (mtx_we),
		.mtx_waddr (mtx_waddr),
		.mtx_wdata (mtx_wdata),
		.mtx_raddr (walk_raddr),
		.mtx_rdata (mtx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q  <= 8'd8;
			num_cols_q  <= 8'd8;
			count_q     <= '0;
			done_q      <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			rd_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_ROWS: num_rows_q <= cfg_data;
					CFG_COLS: num_cols_q <= cfg_data;
					default:  num_rows_q <= num_rows_q;
				endcase
			end
			if (load_acc) begin
				count_q <= count_new;
				done_q  <= s_axis_tlast;
				ovf_q   <= (ovf_q && !done_q) || full;
			end
			rd_s1 <= read_acc;
			if (load_acc || rd_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: zero bits for a load, the masked row word from the memory read register for a read.
	always_ff @(posedge clk) begin
		if (read_acc) begin
			mask_s1 <= mask;
		end
		if (load_acc) begin
			out_bits_q <= '0;
		end else if (rd_s1) begin
			out_bits_q <= mtx_rdata[31:0] & mask_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_bits_q;
	assign m_axis_tuser  = {ovf_q, done_q};

endmodule

// ===== sv/dmp_cw_mem.sv =====
// Codeword store: one write port, one registered read port.
module dmp_cw_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [dmp_pkg::CW_AW-1:0] waddr,
	input  logic [7:0]                wdata,
	input  logic [dmp_pkg::CW_AW-1:0] raddr,
	output logic [7:0]                rdata
);

	logic [7:0] mem [dmp_pkg::MAX_CODEWORDS];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/dmp_mtx_mem.sv =====
// Mapping matrix: row words of 32 module values and 32 filled marks.
module dmp_mtx_mem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [dmp_pkg::MTX_AW-1:0] waddr,
	input  logic [dmp_pkg::MTX_DW-1:0] wdata,
	input  logic [dmp_pkg::MTX_AW-1:0] raddr,
	output logic [dmp_pkg::MTX_DW-1:0] rdata
);

	logic [dmp_pkg::MTX_DW-1:0] mem [dmp_pkg::MTX_DEPTH];
	logic [dmp_pkg::MTX_DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/dmp_walk.sv =====
// Placement sequencer: clears the matrix and walks the diagonal zig-zag.
module dmp_walk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dmp_pkg::walk_req_t         req,
	output logic                       busy,
	output logic [dmp_pkg::CW_AW-1:0]  cw_raddr,
	input  logic [7:0]                 cw_rdata,
	output logic                       mtx_we,
	output logic [dmp_pkg::MTX_AW-1:0] mtx_waddr,
	output logic [dmp_pkg::MTX_DW-1:0] mtx_wdata,
	output logic [dmp_pkg::MTX_AW-1:0] mtx_raddr,
	input  logic [dmp_pkg::MTX_DW-1:0] mtx_rdata
);

	typedef enum logic [10:0] {
		W_IDLE   = 11'b000_0000_0001,
		W_CLR    = 11'b000_0000_0010,
		W_CORNER = 11'b000_0000_0100,
		W_CHK    = 11'b000_0000_1000,
		W_WAIT   = 11'b000_0001_0000,
		W_STEP   = 11'b000_0010_0000,
		W_FETCH  = 11'b000_0100_0000,
		W_LOAD   = 11'b000_1000_0000,
		W_POS    = 11'b001_0000_0000,
		W_RD     = 11'b010_0000_0000,
		W_WR     = 11'b100_0000_0000
	} wstate_t;

	typedef enum logic [1:0] {
		CK_UP  = 2'd0,
		CK_DN  = 2'd1,
		CK_FIX = 2'd2
	} chk_t;

	wstate_t                    state_q, ret_q;
	chk_t                       chk_q;
	dmp_pkg::shape_t            kind_q;
	dmp_pkg::coord_t            r_q, c_q, nr_q, nc_q, br_q, bc_q;
	logic [dmp_pkg::CW_AW-1:0]  pos_q, cnt_q;
	logic [dmp_pkg::MTX_AW-1:0] clr_q;
	logic [2:0]                 k_q, cidx_q;
	logic [7:0]                 byte_q;
	logic                       walk_q;

	dmp_pkg::pos_t   bit_p;
	dmp_pkg::coord_t rn, cn, r2, c2;
	logic            corner_hit, last_k, filled, bit_val;
	dmp_pkg::shape_t corner_kind;
	logic [dmp_pkg::MTX_DW-1:0] word;

	assign busy = (state_q != W_IDLE);

	always_comb begin
		bit_p = dmp_pkg::wrap_pos(dmp_pkg::shape_pos(kind_q, k_q, r_q, c_q, nr_q, nc_q),
			nr_q, nc_q);
		last_k  = (kind_q == dmp_pkg::SH_FIX) ? (k_q == 3'd3) : (k_q == 3'd7);
		filled  = mtx_rdata[{1'b1, c_q[4:0]}];
		bit_val = byte_q[3'd7 - k_q];
		word    = mtx_rdata;
		word[{1'b0, bc_q[4:0]}] = bit_val;
		word[{1'b1, bc_q[4:0]}] = 1'b1;
		corner_hit  = 1'b0;
		corner_kind = dmp_pkg::SH_A;
		unique case (cidx_q)
			3'd0: begin
				corner_hit = (r_q == nr_q) && (c_q == 10'sd0);
			end
			3'd1: begin
				corner_hit  = (r_q == nr_q - 10'sd2) && (c_q == 10'sd0) && (nc_q[1:0] != 2'd0);
				corner_kind = dmp_pkg::SH_B;
			end
			3'd2: begin
				corner_hit  = (r_q == nr_q - 10'sd2) && (c_q == 10'sd0) && (nc_q[2:0] == 3'd4);
				corner_kind = dmp_pkg::SH_C;
			end
			3'd3: begin
				corner_hit  = (r_q == nr_q + 10'sd4) && (c_q == 10'sd2) && (nc_q[2:0] == 3'd0);
				corner_kind = dmp_pkg::SH_D;
			end
			default: begin
				corner_hit = 1'b0;
			end
		endcase
		if (chk_q == CK_UP) begin
			rn = r_q - 10'sd2;
			cn = c_q + 10'sd2;
		end else begin
			rn = r_q + 10'sd2;
			cn = c_q - 10'sd2;
		end
		r2 = rn + 10'sd3;
		c2 = cn + 10'sd1;
	end

	always_comb begin
		cw_raddr  = pos_q;
		mtx_we    = 1'b0;
		mtx_waddr = dmp_pkg::mtx_addr(br_q[7:0], bc_q[7:0]);
		mtx_wdata = word;
		mtx_raddr = dmp_pkg::mtx_addr(br_q[7:0], bc_q[7:0]);
		if (state_q == W_CHK) begin
			mtx_raddr = dmp_pkg::mtx_addr(r_q[7:0], c_q[7:0]);
		end
		if (state_q == W_CLR) begin
			mtx_we    = 1'b1;
			mtx_waddr = clr_q;
			mtx_wdata = '0;
		end
		if (state_q == W_WR) begin
			mtx_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_CLR;
			ret_q   <= W_IDLE;
			chk_q   <= CK_UP;
			kind_q  <= dmp_pkg::SH_UTAH;
			clr_q   <= '0;
			walk_q  <= 1'b0;
			r_q     <= '0;
			c_q     <= '0;
			nr_q    <= 10'sd8;
			nc_q    <= 10'sd8;
			br_q    <= '0;
			bc_q    <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
			cidx_q  <= '0;
			byte_q  <= '0;
		end else begin
			unique case (state_q)
				W_IDLE: begin
					if (req.start) begin
						nr_q    <= dmp_pkg::coord_t'({2'b00, req.nr});
						nc_q    <= dmp_pkg::coord_t'({2'b00, req.nc});
						cnt_q   <= req.count;
						clr_q   <= '0;
						walk_q  <= 1'b1;
						state_q <= W_CLR;
					end
				end
				W_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == dmp_pkg::MTX_LAST) begin
						r_q    <= 10'sd4;
						c_q    <= 10'sd0;
						pos_q  <= '0;
						cidx_q <= '0;
						state_q <= walk_q ? W_CORNER : W_IDLE;
					end
				end
				W_CORNER: begin
					cidx_q <= cidx_q + 1'b1;
					if (cidx_q == 3'd4) begin
						chk_q   <= CK_UP;
						state_q <= W_CHK;
					end else if (corner_hit) begin
						kind_q  <= corner_kind;
						k_q     <= '0;
						ret_q   <= W_CORNER;
						state_q <= W_FETCH;
					end
				end
				W_CHK: begin
					if (dmp_pkg::on_matrix(r_q, c_q, nr_q, nc_q)) begin
						state_q <= W_WAIT;
					end else begin
						state_q <= W_STEP;
					end
				end
				W_WAIT: begin
					if (!filled) begin
						kind_q  <= (chk_q == CK_FIX) ? dmp_pkg::SH_FIX : dmp_pkg::SH_UTAH;
						ret_q   <= (chk_q == CK_FIX) ? W_IDLE : W_STEP;
						k_q     <= '0;
						state_q <= W_FETCH;
					end else begin
						state_q <= (chk_q == CK_FIX) ? W_IDLE : W_STEP;
					end
				end
				W_STEP: begin
					if (chk_q == CK_UP) begin
						if (rn >= 10'sd0 && cn < nc_q) begin
							r_q <= rn;
							c_q <= cn;
						end else begin
							r_q   <= rn + 10'sd1;
							c_q   <= cn + 10'sd3;
							chk_q <= CK_DN;
						end
						state_q <= W_CHK;
					end else if (rn < nr_q && cn >= 10'sd0) begin
						r_q     <= rn;
						c_q     <= cn;
						state_q <= W_CHK;
					end else if (r2 < nr_q || c2 < nc_q) begin
						r_q     <= r2;
						c_q     <= c2;
						cidx_q  <= '0;
						state_q <= W_CORNER;
					end else begin
						// walk over: check the bottom-right corner
						r_q     <= nr_q - 10'sd1;
						c_q     <= nc_q - 10'sd1;
						chk_q   <= CK_FIX;
						state_q <= W_CHK;
					end
				end
				W_FETCH: begin
					if (kind_q == dmp_pkg::SH_FIX) begin
						byte_q  <= dmp_pkg::FIX_BYTE;
						state_q <= W_POS;
					end else begin
						pos_q <= pos_q + 1'b1;
						if (pos_q < cnt_q) begin
							state_q <= W_LOAD;
						end else begin
							byte_q  <= '0;
							state_q <= W_POS;
						end
					end
				end
				W_LOAD: begin
					byte_q  <= cw_rdata;
					state_q <= W_POS;
				end
				W_POS: begin
					br_q    <= bit_p.row;
					bc_q    <= bit_p.col;
					state_q <= W_RD;
				end
				W_RD: begin
					if (dmp_pkg::on_matrix(br_q, bc_q, nr_q, nc_q)) begin
						state_q <= W_WR;
					end else if (last_k) begin
						state_q <= ret_q;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= W_POS;
					end
				end
				W_WR: begin
					if (last_k) begin
						state_q <= ret_q;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= W_POS;
					end
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/dmp_checker.sv =====
// Port-level checks of the placement unit, bound to its top level.
`include "datamatrix_module_placement_unit_defines.svh"

module dmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	`DMP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`DMP_ASSERT_NOW(a_no_take_on_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
	`DMP_ASSERT_NEXT(a_load_result, s_axis_tvalid && s_axis_tready && !s_axis_tuser, m_axis_tvalid && (m_axis_tdata == 32'd0))
	`DMP_ASSERT_NEXT(a_last_placed, s_axis_tvalid && s_axis_tready && !s_axis_tuser && s_axis_tlast, m_axis_tuser[0])

endmodule

bind datamatrix_module_placement_unit dmp_checker u_dmp_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the Data Matrix module placement unit.
`timescale 1ns / 1ps

module testbench;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;
	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;
	localparam int DIM = 132;
	localparam int CW_MAX = 2178;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [31:0] bits;
		logic        placed;
		logic        ovf;
	} row_word_t;

	typedef struct {
		logic        op;
		logic [7:0]  cw;
		logic        last;
		logic [7:0]  row;
		logic [2:0]  word;
		bit          typed;
		row_word_t   want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_idx;
	logic [7:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	// mirror of the symbol state
	logic [7:0] sym_cw[0:CW_MAX-1];
	int         sym_count;
	bit         sym_placed;
	bit         sym_ovf;
	bit         mod_val[0:DIM*DIM-1];
	bit         mod_fill[0:DIM*DIM-1];
	logic [7:0] rows_reg;
	logic [7:0] cols_reg;
	int         walk_nr;
	int         walk_nc;

	row_word_t  pending_words[$];
	stim_row_t  directed[$];
	int         mismatches = 0;
	longint     cycles = 0;
	int         hold_requests;
	bit         calm;

	datamatrix_module_placement_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int sat_dim(logic [7:0] v);
		if (v < 8'd6) return 6;
		if (v > 8'd132) return 132;
		return int'(v);
	endfunction

	function automatic bit filled_at(int r, int c);
		if (r < 0 || r >= walk_nr || c < 0 || c >= walk_nc) return 1'b1;
		return mod_fill[r*DIM + c];
	endfunction

	function automatic void set_module(int r, int c, bit v);
		if (r < 0 || r >= walk_nr || c < 0 || c >= walk_nc) return;
		mod_val[r*DIM + c] = v;
		mod_fill[r*DIM + c] = 1'b1;
	endfunction

	// Write the eight modules of one codeword, MSB first, folding negatives.
	function automatic void put_codeword(int rc[16], int pos);
		logic [7:0] b;
		int r;
		int c;
		b = (pos < sym_count) ? sym_cw[pos] : 8'h00;
		for (int k = 0; k < 8; k++) begin
			r = rc[2*k];
			c = rc[2*k+1];
			if (r < 0) begin
				r += walk_nr;
				c += 4 - ((walk_nr + 4) % 8);
			end
			if (c < 0) begin
				c += walk_nc;
				r += 4 - ((walk_nc + 4) % 8);
			end
			set_module(r, c, b[7-k]);
		end
	endfunction

	function automatic void put_utah(int r, int c, int pos);
		int rc[16];
		rc = '{r-2, c-2, r-2, c-1, r-1, c-2, r-1, c-1, r-1, c, r, c-2, r, c-1, r, c};
		put_codeword(rc, pos);
	endfunction

	function automatic void place_symbol();
		int pos;
		int r;
		int c;
		int n;
		int m;
		int rc[16];
		pos = 0;
		r = 4;
		c = 0;
		walk_nr = sat_dim(rows_reg);
		walk_nc = sat_dim(cols_reg);
		n = walk_nr;
		m = walk_nc;
		for (int i = 0; i < DIM*DIM; i++) begin
			mod_val[i] = 1'b0;
			mod_fill[i] = 1'b0;
		end
		do begin
			if (r == n && c == 0) begin
				rc = '{n-1, 0, n-1, 1, n-1, 2, 0, m-2, 0, m-1, 1, m-1, 2, m-1, 3, m-1};
				put_codeword(rc, pos++);
			end
			if (r == n-2 && c == 0 && (m % 4) != 0) begin
				rc = '{n-3, 0, n-2, 0, n-1, 0, 0, m-4, 0, m-3, 0, m-2, 0, m-1, 1, m-1};
				put_codeword(rc, pos++);
			end
			if (r == n-2 && c == 0 && (m % 8) == 4) begin
				rc = '{n-3, 0, n-2, 0, n-1, 0, 0, m-2, 0, m-1, 1, m-1, 2, m-1, 3, m-1};
				put_codeword(rc, pos++);
			end
			if (r == n+4 && c == 2 && (m % 8) == 0) begin
				rc = '{n-1, 0, n-1, m-1, 0, m-3, 0, m-2, 0, m-1, 1, m-3, 1, m-2, 1, m-1};
				put_codeword(rc, pos++);
			end
			do begin
				if (r >= 0 && r < n && c >= 0 && c < m && !filled_at(r, c))
					put_utah(r, c, pos++);
				r -= 2;
				c += 2;
			end while (r >= 0 && c < m);
			r += 1;
			c += 3;
			do begin
				if (r >= 0 && r < n && c >= 0 && c < m && !filled_at(r, c))
					put_utah(r, c, pos++);
				r += 2;
				c -= 2;
			end while (r < n && c >= 0);
			r += 3;
			c += 1;
		end while (r < n || c < m);
		if (!filled_at(n-1, m-1)) begin
			set_module(n-1, m-1, 1'b1);
			set_module(n-2, m-2, 1'b1);
			set_module(n-1, m-2, 1'b0);
			set_module(n-2, m-1, 1'b0);
		end
	endfunction

	function automatic row_word_t predict_word(logic op, logic [7:0] cw, logic last,
			logic [7:0] row, logic [2:0] word);
		row_word_t w;
		int base;
		w.bits = '0;
		if (op == OP_LOAD) begin
			if (sym_placed) begin
				sym_count = 0;
				sym_placed = 1'b0;
				sym_ovf = 1'b0;
			end
			if (sym_count < CW_MAX) sym_cw[sym_count++] = cw;
			else sym_ovf = 1'b1;
			if (last) begin
				place_symbol();
				sym_placed = 1'b1;
			end
		end else begin
			base = int'(word) * 32;
			if (int'(row) < sat_dim(rows_reg))
				for (int i = 0; i < 32; i++)
					if (base + i < sat_dim(cols_reg) && mod_val[int'(row)*DIM + base + i])
						w.bits[i] = 1'b1;
		end
		w.placed = sym_placed;
		w.ovf = sym_ovf;
		return w;
	endfunction

	task automatic write_reg(logic idx, logic [7:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_NUM_ROWS) rows_reg = val;
		else cols_reg = val;
	endtask

	// Offer one request, hold it until taken, then, unless calm, sometimes idle for a random gap.
	task automatic send_request(logic op, logic [7:0] cw, logic last, logic [7:0] row,
			logic [2:0] word, bit typed, row_word_t want);
		row_word_t w;
		int gap;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = op;
		s_axis_tlast = last;
		s_axis_tdata = {5'b0, word, row, cw};
		do @(posedge clk); while (!s_axis_tready);
		w = predict_word(op, cw, last, row, word);
		pending_words.push_back(typed ? want : w);
		gap = 0;
		if (!calm) begin
			case ($urandom_range(0, 19))
				0: gap = $urandom_range(10, 40);
				1, 2, 3, 4: gap = $urandom_range(1, 3);
				default: gap = 0;
			endcase
		end
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic random_read();
		logic [7:0] row;
		row = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 131))
			: 8'($urandom_range(0, sat_dim(rows_reg) - 1));
		send_request(OP_READ, 8'($urandom), 1'($urandom), row,
			3'($urandom_range(0, 4)), 1'b0, '0);
	endtask

	// Wait for every result, then until the block takes requests again.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		do @(posedge clk); while (!s_axis_tready);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_symbol(logic [7:0] rows, logic [7:0] cols, int ncw, int nreads);
		write_reg(REG_NUM_ROWS, rows);
		write_reg(REG_NUM_COLS, cols);
		for (int i = 0; i < ncw; i++) begin
			if ($urandom_range(0, 9) == 0) random_read();
			send_request(OP_LOAD, 8'($urandom), logic'(i == ncw - 1), 8'($urandom),
				3'($urandom), 1'b0, '0);
		end
		for (int i = 0; i < nreads; i++) random_read();
		drain();
	endtask

	task automatic add_row(logic op, logic [7:0] cw, logic last, logic [7:0] row,
			logic [2:0] word, bit typed, row_word_t want);
		stim_row_t s;
		s.op = op;
		s.cw = cw;
		s.last = last;
		s.row = row;
		s.word = word;
		s.typed = typed;
		s.want = want;
		directed.push_back(s);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Result side: random stalls, one long hold-off on request, compare on accept.
	initial begin : result_side
		int gap_left;
		int holds_done;
		row_word_t got;
		row_word_t want;
		gap_left = 0;
		holds_done = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_done) begin
				holds_done = hold_requests;
				gap_left = 400;
			end
			if (gap_left > 0) begin
				m_axis_tready = 1'b0;
				gap_left--;
			end else if (!calm && $urandom_range(0, 9) < 3) begin
				m_axis_tready = 1'b0;
				gap_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
					: $urandom_range(0, 2);
			end else begin
				m_axis_tready = 1'b1;
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.bits = m_axis_tdata;
				got.placed = m_axis_tuser[0];
				got.ovf = m_axis_tuser[1];
				if (pending_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result bits=%h placed=%b overflow=%b",
							got.bits, got.placed, got.ovf);
				end else begin
					want = pending_words.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: bits exp %h got %h placed exp %b got %b overflow exp %b got %b",
								want.bits, got.bits, want.placed, got.placed, want.ovf, got.ovf);
					end
				end
			end
		end
	end

	initial begin : request_side
		row_word_t zero_w;
		row_word_t done_w;
		int cap;
		logic [7:0] rd;
		logic [7:0] cd;
		hold_requests = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_NUM_ROWS;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		s_axis_tuser = OP_LOAD;
		rows_reg = 8'd8;
		cols_reg = 8'd8;
		sym_count = 0;
		sym_placed = 1'b0;
		sym_ovf = 1'b0;
		walk_nr = 8;
		walk_nc = 8;
		for (int i = 0; i < DIM*DIM; i++) begin
			mod_val[i] = 1'b0;
			mod_fill[i] = 1'b0;
		end
		zero_w = '0;
		done_w = '{bits: 32'h0, placed: 1'b1, ovf: 1'b0};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reads before any placement, an 8x8 symbol, reads out of range, new symbol
		add_row(OP_READ, 8'h00, 1'b0, 8'd0, 3'd0, 1'b1, zero_w);
		add_row(OP_READ, 8'hFF, 1'b1, 8'd131, 3'd4, 1'b1, zero_w);
		add_row(OP_LOAD, 8'h00, 1'b0, 8'hFF, 3'd7, 1'b1, zero_w);
		add_row(OP_LOAD, 8'hFF, 1'b0, 8'h00, 3'd0, 1'b1, zero_w);
		add_row(OP_LOAD, 8'h80, 1'b0, 8'h00, 3'd0, 1'b1, zero_w);
		add_row(OP_LOAD, 8'h01, 1'b0, 8'h00, 3'd0, 1'b1, zero_w);
		add_row(OP_LOAD, 8'h55, 1'b0, 8'h00, 3'd0, 1'b1, zero_w);
		add_row(OP_LOAD, 8'hAA, 1'b0, 8'h00, 3'd0, 1'b1, zero_w);
		add_row(OP_LOAD, 8'h7F, 1'b0, 8'h00, 3'd0, 1'b1, zero_w);
		add_row(OP_LOAD, 8'hFE, 1'b1, 8'h00, 3'd0, 1'b1, done_w);
		for (int r = 0; r < 8; r++)
			add_row(OP_READ, 8'h00, 1'b0, 8'(r), 3'd0, 1'b0, zero_w);
		add_row(OP_READ, 8'h00, 1'b0, 8'd8, 3'd0, 1'b1, done_w);
		add_row(OP_READ, 8'h00, 1'b0, 8'd0, 3'd1, 1'b1, done_w);
		add_row(OP_LOAD, 8'h12, 1'b0, 8'h00, 3'd0, 1'b1, zero_w);
		add_row(OP_READ, 8'h00, 1'b0, 8'd3, 3'd0, 1'b0, zero_w);
		foreach (directed[i])
			send_request(directed[i].op, directed[i].cw, directed[i].last, directed[i].row,
				directed[i].word, directed[i].typed, directed[i].want);
		drain();

		// smallest size, with codewords missing, then saturated sizes
		run_symbol(8'd6, 8'd6, 2, 12);
		run_symbol(8'd0, 8'd255, 30, 20);
		run_symbol(8'd255, 8'd5, 30, 20);

		// full store plus two dropped codewords, without idling
		calm = 1'b1;
		write_reg(REG_NUM_ROWS, 8'd132);
		write_reg(REG_NUM_COLS, 8'd132);
		for (int i = 0; i < CW_MAX + 2; i++)
			send_request(OP_LOAD, 8'($urandom), logic'(i == CW_MAX + 1), 8'h00, 3'd0,
				1'b0, zero_w);
		for (int i = 0; i < 30; i++) random_read();
		drain();
		calm = 1'b0;

		// random small symbols, rows and columns drawn at random from 6 to 26
		for (int s = 0; s < 14; s++) begin
			rd = 8'($urandom_range(6, 26));
			cd = 8'($urandom_range(6, 26));
			cap = sat_dim(rd) * sat_dim(cd) / 8;
			if (s == 3) hold_requests++;
			run_symbol(rd, cd, $urandom_range(1, cap + 3), 12);
		end

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_words.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
